>>> design/skip_pattern_window_max_projector_defines.svh
// assertion macros shared by the checker of the window max projector
// expects clk and arst_n in the scope where a macro is used
`ifndef SKIP_PATTERN_WINDOW_MAX_PROJECTOR_DEFINES_SVH
`define SKIP_PATTERN_WINDOW_MAX_PROJECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SPWMP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define SPWMP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/spwmp_pkg.sv
// types, constants and table helpers of the skip pattern window max projector
// no dependencies
package spwmp_pkg;

	localparam int MAX_SPAN_DEF = 64;
	localparam int COV_W        = 8;
	localparam int CFG_W        = 7;
	// covers distances and spans up to a window of 511
	localparam int SPAN_W       = 9;
	localparam int POS_W        = 32;
	localparam int CYC_ENTRIES  = 1 << CFG_W;

	typedef enum logic [1:0] {
		REG_SPAN  = 2'd0,
		REG_CYCLE = 2'd1,
		REG_USED  = 2'd2,
		REG_TRACK = 2'd3
	} cfg_reg_t;

	// per-item control broadcast to every cell
	typedef struct packed {
		logic              take;
		logic [CFG_W-1:0]  cycle;
		logic [CFG_W-1:0]  used;
		logic [SPAN_W-1:0] span;
		logic [SPAN_W-1:0] pos;
		logic [SPAN_W-1:0] thr;
	} cell_ctl_t;

	typedef logic [SPAN_W-1:0] phase_row_t [0:CYC_ENTRIES-1];

	// distance mod cycle length for every cycle length, distance itself for zero
	function automatic phase_row_t phase_row(input int distance);
		phase_row_t row;
		int r;
		for (int n = 0; n < CYC_ENTRIES; n++) begin
			r = distance;
			if (n != 0) begin
				for (int k = 0; k < (1 << SPAN_W); k++) begin
					if (r >= n) begin
						r = r - n;
					end
				end
			end
			row[n] = SPAN_W'(r);
		end
		return row;
	endfunction

endpackage

>>> design/spwmp_cell.sv
// one window cell: holds the value seen DIST items ago and its masked copy
// depends on spwmp_pkg
module spwmp_cell
	import spwmp_pkg::*;
#(
	parameter int DIST = 1
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [COV_W-1:0] prev_value,
	output logic [COV_W-1:0] value_q,
	output logic [COV_W-1:0] masked_s1
);

	localparam logic [SPAN_W-1:0] DIST_V = SPAN_W'(DIST);
	localparam phase_row_t PHASE = phase_row(DIST);

	logic elig;

	// inside span, inside the current track, on a used phase, source not too late
	assign elig = (DIST_V < ctl.span) && (DIST_V <= ctl.pos) && (DIST_V >= ctl.thr)
		&& (PHASE[ctl.cycle] < SPAN_W'(ctl.used));

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			masked_s1 <= elig ? value_q : '0;
			value_q   <= prev_value;
		end
	end

endmodule

>>> design/spwmp_max_tree.sv
// pipelined maximum over all window cells, four inputs per group, two in a last stage for odd log2(LEAVES)
// depends on spwmp_pkg
module spwmp_max_tree
	import spwmp_pkg::*;
#(
	parameter int LEAVES = MAX_SPAN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_last,
	input  logic [LEAVES*COV_W-1:0] in_data,
	output logic                    in_ready,
	output logic                    out_valid,
	output logic                    out_last,
	output logic [COV_W-1:0]        out_data,
	input  logic                    out_ready
);

	localparam int LOGP = $clog2(LEAVES);
	localparam int P    = 1 << LOGP;
	localparam int LW   = P * COV_W;
	localparam int NST  = (LOGP + 1) / 2;

	wire [LW-1:0] lvl [0:NST];
	wire [NST:0]  vld;
	wire [NST:0]  lst;
	wire [NST:0]  rdy;

	assign lvl[0]   = LW'(in_data);
	assign vld[0]   = in_valid;
	assign lst[0]   = in_last;
	assign rdy[NST] = out_ready;

	for (genvar j = 0; j < NST; j++) begin : g_stage
		localparam int CIN  = P >> (2 * j);
		localparam int GRP  = (CIN >= 4) ? 4 : 2;
		localparam int COUT = CIN / GRP;

		logic [COUT*COV_W-1:0] red;
		logic [COUT*COV_W-1:0] data_q;
		logic                  v_q;
		logic                  last_q;

		always_comb begin
			for (int k = 0; k < COUT; k++) begin
				red[k*COV_W +: COV_W] = lvl[j][(k*GRP)*COV_W +: COV_W];
				for (int g = 1; g < GRP; g++) begin
					if (lvl[j][(k*GRP+g)*COV_W +: COV_W] > red[k*COV_W +: COV_W]) begin
						red[k*COV_W +: COV_W] = lvl[j][(k*GRP+g)*COV_W +: COV_W];
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else if (rdy[j]) begin
				v_q <= vld[j];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && vld[j]) begin
				data_q <= red;
				last_q <= lst[j];
			end
		end

		assign rdy[j]   = !v_q || rdy[j+1];
		assign vld[j+1] = v_q;
		assign lst[j+1] = last_q;
		assign lvl[j+1] = LW'(data_q);
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld[NST];
	assign out_last  = lst[NST];
	assign out_data  = lvl[NST][COV_W-1:0];

endmodule

>>> design/skip_pattern_window_max_projector.sv
// channel  | handshake          | payload
// s_       | s_tvalid/s_tready  | tdata[7:0] coverage_in, tlast last_of_track
// m_       | m_tvalid/m_tready  | tdata[7:0] projected_coverage, tlast last_out
// cfg_     | cfg_we             | cfg_addr register index, cfg_wdata value
//
// one item per cycle sustained while the output is not stalled; each result is
// registered in the cell stage and then in each stage of the registered max tree
// each tree stage has its own valid, so bubbles collapse and s_tready only
// drops when every stage holds an item and the output is stalled
// arst_n clears valids, the position counter and the registers to their defaults
module skip_pattern_window_max_projector
	import spwmp_pkg::*;
#(
	parameter int MAX_SPAN = MAX_SPAN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_addr,
	input  logic [POS_W-1:0] cfg_wdata,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] coverage_in
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // [7:0] projected_coverage
	output logic             m_tlast
);

	logic [CFG_W-1:0]  span_q;
	logic [CFG_W-1:0]  cycle_q;
	logic [CFG_W-1:0]  used_q;
	logic [POS_W-1:0]  track_q;
	logic [POS_W-1:0]  pos_q;

	logic              v_s1;
	logic [COV_W-1:0]  own_s1;
	logic              last_s1;

	logic              take;
	logic              tree_ready;
	logic [SPAN_W-1:0] span_eff;
	logic [SPAN_W-1:0] pos_clamp;
	logic [SPAN_W-1:0] thr;
	logic [POS_W+1:0]  t_diff;
	cell_ctl_t         ctl;

	wire [COV_W-1:0]          chain  [0:MAX_SPAN-1];
	wire [MAX_SPAN*COV_W-1:0] tree_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q  <= CFG_W'(1);
			cycle_q <= CFG_W'(1);
			used_q  <= CFG_W'(1);
			track_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_SPAN:  span_q  <= cfg_wdata[CFG_W-1:0];
				REG_CYCLE: cycle_q <= cfg_wdata[CFG_W-1:0];
				REG_USED:  used_q  <= cfg_wdata[CFG_W-1:0];
				REG_TRACK: track_q <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	assign s_tready = !v_s1 || tree_ready;
	assign take     = s_tvalid && s_tready;

	// a source at distance d counts when d >= pos + span + 1 - track_length
	always_comb begin
		span_eff  = (SPAN_W'(span_q) > SPAN_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN)
			: SPAN_W'(span_q);
		pos_clamp = (pos_q >= POS_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN) : pos_q[SPAN_W-1:0];
		t_diff    = {2'b00, pos_q} + (POS_W+2)'(span_eff) + (POS_W+2)'(1)
			- {2'b00, track_q};
		priority if (t_diff[POS_W+1] || (t_diff == '0)) begin
			thr = '0;
		end else if (t_diff > (POS_W+2)'(MAX_SPAN)) begin
			thr = SPAN_W'(MAX_SPAN);
		end else begin
			thr = t_diff[SPAN_W-1:0];
		end
		ctl.take  = take;
		ctl.cycle = cycle_q;
		ctl.used  = used_q;
		ctl.span  = span_eff;
		ctl.pos   = pos_clamp;
		ctl.thr   = thr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (take) begin
				pos_q <= s_tlast ? '0 : pos_q + POS_W'(1);
			end
			if (take) begin
				v_s1 <= 1'b1;
			end else if (tree_ready) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			own_s1  <= s_tdata[COV_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	assign chain[0]               = s_tdata[COV_W-1:0];
	assign tree_in[COV_W-1:0]     = own_s1;

	for (genvar k = 1; k < MAX_SPAN; k++) begin : g_cell
		spwmp_cell #(
			.DIST(k)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.prev_value (chain[k-1]),
			.value_q    (chain[k]),
			.masked_s1  (tree_in[k*COV_W +: COV_W])
		);
	end

	spwmp_max_tree #(
		.LEAVES(MAX_SPAN)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_last   (last_s1),
		.in_data   (tree_in),
		.in_ready  (tree_ready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_data  (m_tdata),
		.out_ready (m_tready)
	);

endmodule

>>> design/spwmp_check.sv
// port-level checker for the skip pattern window max projector, bound to the top
// depends on skip_pattern_window_max_projector_defines.svh
`include "skip_pattern_window_max_projector_defines.svh"

module spwmp_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	logic       in_xfer;
	logic       out_xfer;
	logic [7:0] open_q;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// items taken in whose results are not delivered yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			open_q <= open_q + 8'd1;
		end else if (out_xfer && !in_xfer) begin
			open_q <= open_q - 8'd1;
		end
	end

	`SPWMP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
	`SPWMP_ASSERT_IMP(a_no_extra, out_xfer, open_q != 8'd0, "result without a pending item")
	`SPWMP_ASSERT_IMP(a_idle_ready, open_q == 8'd0, s_tready, "empty block refuses input")

endmodule

bind skip_pattern_window_max_projector spwmp_check u_spwmp_check (.*);

>>> tb/tb_skip_pattern_window_max_projector.sv
// testbench for skip_pattern_window_max_projector: directed and random tracks of coverage
// values, checked against a scoreboard that predicts each projected value
// depends on spwmp_pkg and the projector rtl
module tb_skip_pattern_window_max_projector;
	import spwmp_pkg::*;

	localparam int LATENCY  = 4;
	localparam int HIST_LEN = MAX_SPAN_DEF - 1;

	typedef struct packed {
		logic [7:0] cov;
		logic       last;
	} proj_item_t;

	class coverage_scoreboard;
		logic [6:0]       span;
		logic [6:0]       cyc;
		logic [6:0]       used;
		logic [POS_W-1:0] track_len;
		logic [7:0]       history [0:HIST_LEN-1];
		logic [POS_W-1:0] pos;
		proj_item_t       expected_q [$];
		int               errors;

		function new();
			span = 7'd1;
			cyc = 7'd1;
			used = 7'd1;
			track_len = '0;
			pos = '0;
			errors = 0;
			foreach (history[k]) history[k] = 8'd0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] val);
			case (idx)
				REG_SPAN:  span = val[6:0];
				REG_CYCLE: cyc = val[6:0];
				REG_USED:  used = val[6:0];
				REG_TRACK: track_len = val;
				default: ;
			endcase
		endfunction

		// does the value gap positions back feed the current position
		function bit is_source(int unsigned gap, int unsigned eff_span);
			longint unsigned phase;
			longint unsigned src;
			if (longint'(gap) > longint'(pos)) return 1'b0;
			phase = (cyc != 0) ? (gap % cyc) : gap;
			if (phase >= used) return 1'b0;
			src = longint'(pos) - gap;
			return (src + eff_span + 1) <= longint'(track_len);
		endfunction

		function void note_input(logic [7:0] own, logic last);
			int unsigned eff_span;
			logic [7:0] best;
			proj_item_t exp_item;
			eff_span = (span > MAX_SPAN_DEF) ? MAX_SPAN_DEF : span;
			best = own;
			for (int unsigned gap = 1; gap < eff_span; gap++) begin
				if (is_source(gap, eff_span) && history[gap-1] > best) best = history[gap-1];
			end
			for (int k = HIST_LEN - 1; k > 0; k--) history[k] = history[k-1];
			history[0] = own;
			pos = last ? '0 : pos + 1;
			exp_item.cov = best;
			exp_item.last = last;
			expected_q.push_back(exp_item);
		endfunction

		function void check_result(logic [7:0] cov, logic last);
			proj_item_t exp_item;
			if (expected_q.size() == 0) begin
				$error("output transfer with nothing expected: projected_coverage %0d", cov);
				errors++;
				return;
			end
			exp_item = expected_q.pop_front();
			if (cov !== exp_item.cov) begin
				$error("projected_coverage expected %0d got %0d", exp_item.cov, cov);
				errors++;
			end
			if (last !== exp_item.last) begin
				$error("last_out expected %0d got %0d", exp_item.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_addr = '0;
	logic [POS_W-1:0] cfg_wdata = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;   // [7:0] coverage_in
	logic             s_tlast = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;        // [7:0] projected_coverage
	logic             m_tlast;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;

	coverage_scoreboard sb = new();

	skip_pattern_window_max_projector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
	end

	// leaves cfg_we high, the caller lowers it after the last write
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic configure(input logic [31:0] sp, input logic [31:0] cy,
			input logic [31:0] us, input logic [31:0] tl);
		write_reg(REG_SPAN, sp);
		write_reg(REG_CYCLE, cy);
		write_reg(REG_USED, us);
		write_reg(REG_TRACK, tl);
		cfg_we <= 1'b0;
	endtask

	task automatic send_item(input logic [7:0] cov, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= cov;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_input(cov, last);
	endtask

	// sender pauses until every projected value is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// one nonzero value followed by zeros shows how far it is projected
	task automatic send_burst(input logic [7:0] head, input int len);
		for (int i = 0; i < len; i++) begin
			send_item((i == 0) ? head : 8'd0, i == len - 1);
		end
	endtask

	function automatic logic [7:0] pick_cov();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// noisy runs drop the last flag at random places
	task automatic send_track(input int len, input bit noisy, inout int sent);
		for (int i = 0; i < len; i++) begin
			send_item(pick_cov(), noisy ? ($urandom_range(15) == 0) : (i == len - 1));
			sent++;
		end
	endtask

	initial begin
		int unsigned sp;
		int unsigned cy;
		int unsigned us;
		int unsigned eff_span;
		logic [31:0] tl;
		int sent;
		int len;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: no window at all
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'hAA, 1'b1);
		wait_drained();
		// oversized span clamps, zero cycle length means no wrap
		configure(32'd127, 32'd0, 32'd3, 32'hFFFF_FFFF);
		send_item(8'hFF, 1'b0);
		send_burst(8'h80, 5);
		wait_drained();
		// nothing used per cycle
		configure(32'd10, 32'd4, 32'd0, 32'd100);
		send_burst(8'd200, 3);
		wait_drained();
		// every gap counts when used covers the cycle
		configure(32'd8, 32'd3, 32'd64, 32'd200);
		send_burst(8'd250, 4);
		wait_drained();
		// track too short to have any source
		configure(32'd8, 32'd3, 32'd64, 32'd5);
		send_burst(8'd250, 3);
		wait_drained();
		configure(32'd0, 32'd64, 32'd64, 32'd20);
		send_burst(8'd99, 2);
		wait_drained();

		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 62; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 62; end
				default: begin src_idle_pct = 24; snk_stall_pct = 24; end
			endcase
			case ($urandom_range(19))
				0: sp = 0;
				1: sp = $urandom_range(65, 127);
				2: sp = 64;
				default: sp = $urandom_range(1, 64);
			endcase
			case ($urandom_range(9))
				0: cy = 0;
				1: cy = $urandom_range(65, 127);
				default: cy = $urandom_range(1, 64);
			endcase
			case ($urandom_range(9))
				0: us = 0;
				1: us = $urandom_range(64, 127);
				default: us = $urandom_range(1, 64);
			endcase
			eff_span = (sp > MAX_SPAN_DEF) ? MAX_SPAN_DEF : sp;
			case ($urandom_range(9))
				0: tl = 32'd0;
				1: tl = 32'hFFFF_FFFF;
				2: tl = $urandom;
				default: tl = eff_span + 1 + $urandom_range(0, 60);
			endcase
			// upper bits of the short registers are don't-care
			configure(($urandom & 32'hFFFF_FF80) | sp, ($urandom & 32'hFFFF_FF80) | cy,
				($urandom & 32'hFFFF_FF80) | us, tl);
			sent = 0;
			while (sent < 80) begin
				if ($urandom_range(3) != 0 && tl >= 1 && tl <= 200) len = tl;
				else len = $urandom_range(1, 90);
				send_track(len, $urandom_range(7) == 0, sent);
			end
			wait_drained();
		end

		src_idle_pct = 0;
		snk_stall_pct = 0;
		repeat (LATENCY + 8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
